>>> rtl/sfq_pkg.sv
package sfq_pkg;

    typedef logic [31:0] freq_t;
    typedef logic [1:0]  status_t;
    typedef logic [1:0]  band_t;

    typedef struct packed {
        logic  ok;
        freq_t freq;
    } fold_res_t;

    localparam status_t ST_WAIT     = 2'd0;
    localparam status_t ST_MISMATCH = 2'd1;
    localparam status_t ST_OUTBAND  = 2'd2;
    localparam status_t ST_LOCKED   = 2'd3;

    localparam band_t BAND_UHF  = 2'd0;
    localparam band_t BAND_VHF  = 2'd1;
    localparam band_t BAND_200M = 2'd2;
    localparam band_t BAND_350M = 2'd3;

    localparam logic [1:0] REG_BAND_SELECT = 2'd0;
    localparam logic [1:0] REG_CORR_COEFF  = 2'd1;
    localparam logic [1:0] REG_CORR_SUB    = 2'd2;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_FREQ_W  = 26;
    localparam int PIPE_DEPTH  = 10;

    localparam int PAIR_TOL = 25;

    localparam freq_t F_52M = 32'd52000000;
    localparam freq_t F_40M = 32'd40000000;
    localparam freq_t F_36M = 32'd36000000;
    localparam freq_t F_25M = 32'd25000000;
    localparam freq_t F_10M = 32'd10000000;
    localparam freq_t F_20M = 32'd20000000;
    localparam freq_t F_30M = 32'd30000000;
    localparam freq_t F_70M = 32'd70000000;
    localparam freq_t F_26M = 32'd26000000;
    localparam freq_t F_39M = 32'd39000000;
    localparam freq_t F_35M = 32'd35000000;
    localparam freq_t F_17M4 = 32'd17400000;
    localparam freq_t F_13M6 = 32'd13600000;

    // n / 3 for any 32-bit n: (n * DIV3_MUL) >> 33
    localparam logic [31:0] DIV3_MUL   = 32'hAAAAAAAB;
    localparam int          DIV3_SHIFT = 33;

    // n / 25 for any 32-bit n: (n * DIV25_MUL) >> 35
    localparam logic [31:0] DIV25_MUL   = 32'h51EB851F;
    localparam int          DIV25_SHIFT = 35;
    localparam int          ROUND_STEP  = 25;
    localparam int          ROUND_BIAS  = 13;

    // p / 10^7 = (p >> 7) / 78125, estimated from the top bits then corrected
    localparam logic [16:0] CORR_DIV     = 17'd78125;
    localparam logic [31:0] CORR_REC_MUL = 32'd3602879701;
    localparam int          CORR_REC_SHIFT = 39;

endpackage

>>> rtl/sfq_fold.sv
module sfq_fold
    import sfq_pkg::*;
(
    input  band_t     band,
    input  freq_t     avg,
    input  freq_t     third,
    output fold_res_t res
);

    freq_t half;

    assign half = avg >> 1;

    always_comb
    begin
        res.ok   = 1'b1;
        res.freq = avg;
        case (band)
            BAND_UHF:
            begin
                if (avg > F_52M)
                begin
                    res.freq = half;
                end
                if (res.freq < F_40M)
                begin
                    res.ok = 1'b0;
                end
            end
            BAND_VHF:
            begin
                if (avg >= F_36M)
                begin
                    res.freq = third;
                end
                else if (avg > F_25M)
                begin
                    res.freq = half;
                end
                else if (avg < F_10M)
                begin
                    res.ok = 1'b0;
                end
                if (res.freq > F_20M)
                begin
                    res.ok = 1'b0;
                end
            end
            BAND_200M:
            begin
                if (avg >= F_40M)
                begin
                    res.freq = half;
                end
                else if (avg < F_20M)
                begin
                    res.ok = 1'b0;
                end
                if (res.freq > F_30M)
                begin
                    res.ok = 1'b0;
                end
            end
            default:
            begin
                if (avg >= F_70M)
                begin
                    res.freq = half;
                end
                else if (avg < F_30M)
                begin
                    res.ok = 1'b0;
                end
                if (res.freq > F_40M)
                begin
                    res.ok = 1'b0;
                end
            end
        endcase
    end

endmodule

>>> rtl/scan_frequency_qualifier.sv
// Pairs frequency-counter readings (10 Hz units) and qualifies them: a zero
// reading leaves the pair state unchanged, the first reading of a pair is
// held, and the second either rejects the pair (difference of 25 or more),
// or averages the two, folds harmonics for the selected band, applies the
// crystal correction, rounds to 250 Hz and clamps to the band limits (a
// 350 MHz band result below 300 MHz is raised to 350 MHz). Every accepted
// reading gives exactly one result word. The block takes one reading per
// clock while in_stall is low. Each result passes through the ten-stage
// arithmetic pipeline (divide by three, correction multiply, divide by ten
// million, divide by 25, each a registered multiply). Pair state is updated
// in the cycle a reading is accepted, so back-to-back readings pair
// correctly. Stalls on the result side fill empty pipeline slots before the
// reading side is stalled. Configuration writes take effect at once and are
// expected only while the block is idle.
module scan_frequency_qualifier
    import sfq_pkg::*;
#(
    parameter int READING_BITS = 27
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [READING_BITS-1:0] reading,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [OUT_FREQ_W-1:0]   locked_freq
);

    band_t       band_reg;
    logic [15:0] coeff_reg;
    logic        sub_reg;

    logic [READING_BITS-1:0] first_reg;
    logic                    have_first_reg;

    logic [PIPE_DEPTH:1] v_reg;
    logic [PIPE_DEPTH:1] en;
    logic                in_acc;

    // stage 0 combinational
    logic [READING_BITS-1:0] diff;
    logic [READING_BITS:0]   sum;
    status_t                 st0;

    // pipeline payload
    status_t     st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    status_t     st6_reg, st7_reg, st8_reg, st9_reg, st10_reg;
    freq_t       avg1_reg, avg2_reg;
    logic [30:0] third2_reg;
    freq_t       f3_reg, f4_reg, f5_reg, f6_reg, f7_reg;
    logic [47:0] prod4_reg;
    logic [40:0] x5_reg, x6_reg;
    logic [24:0] q5_reg, q6_reg;
    logic [41:0] qm6_reg;
    logic [24:0] c7_reg;
    freq_t       g8_reg;
    logic [28:0] q9_reg;
    logic [OUT_FREQ_W-1:0] freq10_reg;

    logic [63:0] mul3;
    fold_res_t   fold;
    logic [63:0] mul_rec;
    logic [40:0] rem;
    logic [24:0] c_next;
    freq_t       g_next;
    logic [63:0] mul25;
    freq_t       rounded;
    freq_t       clamped;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg  <= BAND_UHF;
            coeff_reg <= '0;
            sub_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BAND_SELECT: band_reg  <= cfg_data[1:0];
                REG_CORR_COEFF:  coeff_reg <= cfg_data;
                REG_CORR_SUB:    sub_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // flow control: a slot loads when it is empty or its word moves on
    always_comb
    begin
        en[PIPE_DEPTH] = !v_reg[PIPE_DEPTH] || !out_stall;
        for (int i = PIPE_DEPTH - 1; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i + 1];
        end
    end

    assign in_stall  = !en[1];
    assign in_acc    = in_valid && en[1];
    assign out_valid = v_reg[PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_acc;
            end
            for (int i = 2; i <= PIPE_DEPTH; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    // pairing
    assign diff = (first_reg > reading) ? (first_reg - reading) : (reading - first_reg);
    assign sum  = {1'b0, first_reg} + {1'b0, reading};

    always_comb
    begin
        st0 = ST_WAIT;
        if (reading != '0 && have_first_reg)
        begin
            st0 = (diff < READING_BITS'(PAIR_TOL)) ? ST_LOCKED : ST_MISMATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= '0;
            have_first_reg <= 1'b0;
        end
        else if (in_acc && reading != '0)
        begin
            if (!have_first_reg)
            begin
                first_reg      <= reading;
                have_first_reg <= 1'b1;
            end
            else
            begin
                have_first_reg <= 1'b0;
            end
        end
    end

    // stage 1: average
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            st1_reg  <= st0;
            avg1_reg <= 32'(sum[READING_BITS:1]);
        end
    end

    // stage 2: divide by three
    assign mul3 = 64'(avg1_reg) * 64'(DIV3_MUL);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            st2_reg    <= st1_reg;
            avg2_reg   <= avg1_reg;
            third2_reg <= mul3[DIV3_SHIFT +: 31];
        end
    end

    // stage 3: harmonic fold and band check
    sfq_fold u_fold
    (
        .band  (band_reg),
        .avg   (avg2_reg),
        .third ({1'b0, third2_reg}),
        .res   (fold)
    );

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            st3_reg <= (st2_reg == ST_LOCKED && !fold.ok) ? ST_OUTBAND : st2_reg;
            f3_reg  <= fold.freq;
        end
    end

    // stage 4: correction product
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            st4_reg   <= st3_reg;
            f4_reg    <= f3_reg;
            prod4_reg <= 48'(f3_reg) * 48'(coeff_reg);
        end
    end

    // stage 5: quotient estimate by reciprocal
    assign mul_rec = 64'(prod4_reg[47:16]) * 64'(CORR_REC_MUL);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            st5_reg <= st4_reg;
            f5_reg  <= f4_reg;
            x5_reg  <= prod4_reg[47:7];
            q5_reg  <= mul_rec[CORR_REC_SHIFT +: 25];
        end
    end

    // stage 6: back-multiply estimate
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            st6_reg <= st5_reg;
            f6_reg  <= f5_reg;
            x6_reg  <= x5_reg;
            q6_reg  <= q5_reg;
            qm6_reg <= 42'(q5_reg) * 42'(CORR_DIV);
        end
    end

    // stage 7: estimate is low by at most two
    assign rem = x6_reg - qm6_reg[40:0];

    always_comb
    begin
        if (rem >= 41'(CORR_DIV) + 41'(CORR_DIV))
        begin
            c_next = q6_reg + 25'd2;
        end
        else if (rem >= 41'(CORR_DIV))
        begin
            c_next = q6_reg + 25'd1;
        end
        else
        begin
            c_next = q6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            st7_reg <= st6_reg;
            f7_reg  <= f6_reg;
            c7_reg  <= c_next;
        end
    end

    // stage 8: apply correction, add rounding bias
    always_comb
    begin
        if (sub_reg)
        begin
            g_next = (32'(c7_reg) <= f7_reg) ? (f7_reg - 32'(c7_reg)) : '0;
        end
        else
        begin
            g_next = f7_reg + 32'(c7_reg);
        end
        g_next = g_next + 32'(ROUND_BIAS);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            st8_reg <= st7_reg;
            g8_reg  <= g_next;
        end
    end

    // stage 9: divide by 25
    assign mul25 = 64'(g8_reg) * 64'(DIV25_MUL);

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            st9_reg <= st8_reg;
            q9_reg  <= mul25[DIV25_SHIFT +: 29];
        end
    end

    // stage 10: back to 10 Hz units and band clamp
    assign rounded = 32'(34'(q9_reg) * 34'(ROUND_STEP));

    always_comb
    begin
        case (band_reg)
            BAND_VHF:
            begin
                if (rounded > F_17M4)      clamped = F_17M4;
                else if (rounded < F_13M6) clamped = F_13M6;
                else                       clamped = rounded;
            end
            BAND_200M:
            begin
                if (rounded > F_26M)      clamped = F_26M;
                else if (rounded < F_20M) clamped = F_20M;
                else                      clamped = rounded;
            end
            BAND_350M:
            begin
                if (rounded > F_39M)      clamped = F_39M;
                else if (rounded < F_30M) clamped = F_35M;
                else                      clamped = rounded;
            end
            default:
            begin
                if (rounded > F_52M)      clamped = F_52M;
                else if (rounded < F_40M) clamped = F_40M;
                else                      clamped = rounded;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            st10_reg   <= st9_reg;
            freq10_reg <= (st9_reg == ST_LOCKED) ? clamped[OUT_FREQ_W-1:0] : '0;
        end
    end

    assign status      = st10_reg;
    assign locked_freq = freq10_reg;

    // checks
    a_freq_zero_unless_locked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_LOCKED |-> locked_freq == '0)
        else $error("frequency word without lock");

    a_locked_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_LOCKED |->
            locked_freq >= OUT_FREQ_W'(F_13M6) && locked_freq <= OUT_FREQ_W'(F_52M))
        else $error("locked frequency outside all band limits");

    a_first_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && reading != '0 && !have_first_reg |=> have_first_reg && first_reg == $past(reading))
        else $error("first reading of a pair not held");

    a_pair_closed: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && reading != '0 && have_first_reg |=> !have_first_reg)
        else $error("pair not closed on second reading");

    a_zero_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && reading == '0 |=> $stable(have_first_reg))
        else $error("zero reading changed pair state");

endmodule
